### design/repeated_word_vote_with_holdoff_defines.svh
// Assertion macros shared by the checker of the repeated-word vote block.
// Depends on nothing; include by bare file name.
`ifndef REPEATED_WORD_VOTE_WITH_HOLDOFF_DEFINES_SVH
`define REPEATED_WORD_VOTE_WITH_HOLDOFF_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define RWVH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define RWVH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/rwvh_pkg.sv
// Types and fixed constants of the repeated-word vote block.
// No dependencies; imported by the top level.
package rwvh_pkg;

	localparam int WORD_COUNT = 8;
	localparam int WORD_W     = 16;
	localparam int MSG_W      = 15;
	localparam int THR_W      = 3;
	localparam int HOLD_W     = 16;
	localparam int CNT_W      = $clog2(WORD_COUNT);
	localparam int IDX_W      = $clog2(WORD_COUNT);
	localparam int CMP_W      = (CNT_W > THR_W) ? CNT_W : THR_W;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// Register select taken from paddr[2].
	localparam logic REG_THRESHOLD = 1'b0;
	localparam logic REG_HOLDOFF   = 1'b1;

	localparam logic [THR_W-1:0]  THRESHOLD_RST = THR_W'(3);
	localparam logic [HOLD_W-1:0] HOLDOFF_RST   = HOLD_W'(10);

	typedef logic signed [WORD_W-1:0] word_t;

	typedef struct packed {
		logic             accepted;
		logic [MSG_W-1:0] message;
		logic             flush_request;
	} result_t;

endpackage

### design/repeated_word_vote_with_holdoff.sv
// Repeated-word vote with holdoff: one tick beat in, one result beat out.
// Path: a taken tick beat passes the input register, then the result register, and
// leaves as the result beat; a stall on the result channel can hold it in either one.
// Throughput: one beat per cycle unless result_stall holds it; the vote compares and the
// holdoff counter update sit between the two registers, where the counter closes its loop.
// Reset (arst_n low, asynchronous): pipeline empty, holdoff counter 0, threshold 3,
// holdoff ticks 10. Depends on rwvh_pkg.
module repeated_word_vote_with_holdoff (
	input  logic                          clk,
	input  logic                          arst_n,
	// tick channel
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic                          packet_present,
	input  rwvh_pkg::word_t               word_0,
	input  rwvh_pkg::word_t               word_1,
	input  rwvh_pkg::word_t               word_2,
	input  rwvh_pkg::word_t               word_3,
	input  rwvh_pkg::word_t               word_4,
	input  rwvh_pkg::word_t               word_5,
	input  rwvh_pkg::word_t               word_6,
	input  rwvh_pkg::word_t               word_7,
	// result channel
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          accepted,
	output logic [rwvh_pkg::MSG_W-1:0]    message,
	output logic                          flush_request,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rwvh_pkg::PADDR_W-1:0]  paddr,
	input  logic [rwvh_pkg::PDATA_W-1:0]  pwdata,
	output logic [rwvh_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import rwvh_pkg::*;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [THR_W-1:0]  threshold_q;
	logic [HOLD_W-1:0] holdoff_ticks_q;
	logic              cfg_wr;
	logic              reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q     <= THRESHOLD_RST;
			holdoff_ticks_q <= HOLDOFF_RST;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_THRESHOLD: threshold_q     <= pwdata[THR_W-1:0];
				REG_HOLDOFF:   holdoff_ticks_q <= pwdata[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_THRESHOLD: prdata = PDATA_W'(threshold_q);
			REG_HOLDOFF:   prdata = PDATA_W'(holdoff_ticks_q);
			default:       prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Pipeline control: stage 1 is the input register, stage 2 the
	// result register. Stage 2 moves when it is empty or its beat is
	// taken; stage 1 then hands over and can take a new beat the same
	// cycle, so a waiting result blocks the next tick only if stage 1 is full.
	// ---------------------------------------------------------------
	logic    valid_s1;
	logic    valid_s2;
	logic    advance;
	logic    take_in;

	assign advance    = !valid_s2 || !result_stall;
	assign item_stall = valid_s1 && !advance;
	assign take_in    = item_valid && !item_stall;

	// Stage 1 payload
	logic  present_s1;
	word_t word_s1 [WORD_COUNT];
	word_t word_in [WORD_COUNT];

	assign word_in[0] = word_0;
	assign word_in[1] = word_1;
	assign word_in[2] = word_2;
	assign word_in[3] = word_3;
	assign word_in[4] = word_4;
	assign word_in[5] = word_5;
	assign word_in[6] = word_6;
	assign word_in[7] = word_7;

	always_ff @(posedge clk) begin
		if (take_in) begin
			present_s1 <= packet_present;
			word_s1    <= word_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// ---------------------------------------------------------------
	// Vote: for each candidate count the equal words after it, then
	// pick the lowest candidate that reaches the threshold.
	// ---------------------------------------------------------------
	logic [CNT_W-1:0]      match_cnt [WORD_COUNT-1];
	logic [WORD_COUNT-2:0] qualifies;
	logic                  found;
	logic [IDX_W-1:0]      pick;
	word_t                 pick_word;
	logic                  pick_positive;

	always_comb begin
		for (int i = 0; i < WORD_COUNT - 1; i++) begin
			match_cnt[i] = '0;
			for (int j = i + 1; j < WORD_COUNT; j++) begin
				if (word_s1[j] == word_s1[i]) begin
					match_cnt[i] = match_cnt[i] + CNT_W'(1);
				end
			end
			qualifies[i] = CMP_W'(match_cnt[i]) >= CMP_W'(threshold_q);
		end
	end

	always_comb begin
		found = |qualifies;
		pick  = '0;
		// scan from the top down so the lowest index wins
		for (int i = WORD_COUNT - 2; i >= 0; i--) begin
			if (qualifies[i]) begin
				pick = IDX_W'(i);
			end
		end
	end

	assign pick_word     = word_s1[pick];
	assign pick_positive = !pick_word[WORD_W-1] && (pick_word != '0);

	// ---------------------------------------------------------------
	// Holdoff counter and result of the tick in stage 1.
	// ---------------------------------------------------------------
	logic [HOLD_W-1:0] holdoff_q;
	logic [HOLD_W-1:0] holdoff_next;
	logic              hold_active;
	result_t           res_next;
	result_t           res_s2;

	assign hold_active = holdoff_q != '0;

	always_comb begin
		res_next     = '0;
		holdoff_next = holdoff_q;
		if (present_s1 && !hold_active) begin
			// vote only when no holdoff is running
			if (found && pick_positive) begin
				res_next.accepted = 1'b1;
				res_next.message  = pick_word[MSG_W-1:0];
				holdoff_next      = holdoff_ticks_q;
			end
		end else if (hold_active) begin
			// drop the packet, count down and ask for a flush
			holdoff_next           = holdoff_q - HOLD_W'(1);
			res_next.flush_request = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_q <= '0;
			valid_s2  <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				holdoff_q <= holdoff_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res_next;
		end
	end

	assign result_valid  = valid_s2;
	assign accepted      = res_s2.accepted;
	assign message       = res_s2.message;
	assign flush_request = res_s2.flush_request;

endmodule

### design/rwvh_checker.sv
// Port-level checker of the repeated-word vote block and its bind.
// Depends on repeated_word_vote_with_holdoff_defines.svh.
`include "repeated_word_vote_with_holdoff_defines.svh"

module rwvh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_stall,
	input logic        accepted,
	input logic [14:0] message,
	input logic        flush_request
);

	// an accepted word is always positive, so never zero
	`RWVH_ASSERT_NOW(a_accept_nonzero, clk, arst_n, result_valid && accepted, message != '0, "accepted beat carries a zero message")

	// no acceptance means the message field is cleared
	`RWVH_ASSERT_NOW(a_reject_clear, clk, arst_n, result_valid && !accepted, message == '0, "rejected beat carries a message")

	// a tick either votes or counts down, never both
	`RWVH_ASSERT_NOW(a_accept_xor_flush, clk, arst_n, result_valid && accepted, !flush_request, "accept and flush in one beat")

	// hold a stalled result
	`RWVH_ASSERT_NEXT(a_stall_hold, clk, arst_n, result_valid && result_stall, result_valid, "stalled result beat dropped")

endmodule

bind repeated_word_vote_with_holdoff rwvh_checker u_rwvh_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.result_valid  (result_valid),
	.result_stall  (result_stall),
	.accepted      (accepted),
	.message       (message),
	.flush_request (flush_request)
);
